>>> hdl/yc2rgb_pkg.sv
// Shared types, register codes and coefficient helpers for the pixel-pair
// YCbCr to BGR converter. No dependencies.
`default_nettype none

package yc2rgb_pkg;

  // Fraction bits of the Q2.x coefficients; the 12-bit registers fit Q2.10
  localparam int COEF_FRAC_BITS = 10;

  // Register file geometry
  localparam int NUM_REGS   = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int COEF_W     = 12;
  localparam int PIX_W      = 8;

  // Product and accumulator widths (12b unsigned x 9b signed, three-term sum)
  localparam int PROD_W = 22;
  localparam int ACC_W  = 24;

  // Standard BT.601 limited-range coefficients in thousandths
  localparam int LUMA_GAIN_MILLI   = 1164;
  localparam int CR_TO_RED_MILLI   = 1596;
  localparam int CR_TO_GREEN_MILLI = 813;
  localparam int CB_TO_GREEN_MILLI = 391;
  localparam int CB_TO_BLUE_MILLI  = 2018;
  localparam int MILLI_SCALE       = 1000;

  localparam logic [PIX_W-1:0] LUMA_OFFSET_RESET   = 8'd16;
  localparam logic [PIX_W-1:0] CHROMA_CENTER_RESET = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LUMA_GAIN     = 3'd0,
    REG_LUMA_OFFSET   = 3'd1,
    REG_CHROMA_CENTER = 3'd2,
    REG_CR_TO_RED     = 3'd3,
    REG_CR_TO_GREEN   = 3'd4,
    REG_CB_TO_GREEN   = 3'd5,
    REG_CB_TO_BLUE    = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] luma_left;
    logic [PIX_W-1:0] luma_right;
    logic [PIX_W-1:0] chroma_red;
    logic [PIX_W-1:0] chroma_blue;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue_left;
    logic [PIX_W-1:0] green_left;
    logic [PIX_W-1:0] red_left;
    logic [PIX_W-1:0] blue_right;
    logic [PIX_W-1:0] green_right;
    logic [PIX_W-1:0] red_right;
  } pix_out_t;

  typedef struct packed {
    logic [COEF_W-1:0] luma_gain;
    logic [PIX_W-1:0]  luma_offset;
    logic [PIX_W-1:0]  chroma_center;
    logic [COEF_W-1:0] cr_to_red;
    logic [COEF_W-1:0] cr_to_green;
    logic [COEF_W-1:0] cb_to_green;
    logic [COEF_W-1:0] cb_to_blue;
  } cfg_t;

  // Products of one pixel pair, fed to the sum logic
  typedef struct packed {
    logic signed [PROD_W-1:0] yterm_left;
    logic signed [PROD_W-1:0] yterm_right;
    logic signed [PROD_W-1:0] cr_red;
    logic signed [PROD_W-1:0] cr_green;
    logic signed [PROD_W-1:0] cb_green;
    logic signed [PROD_W-1:0] cb_blue;
  } prod_t;

  // Fixed-point coefficient from thousandths, rounded to nearest
  function automatic logic [COEF_W-1:0] coef_fixed(int milli, int frac_bits);
    int scaled;
    scaled = ((milli << frac_bits) + MILLI_SCALE / 2) / MILLI_SCALE;
    return scaled[COEF_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/yc2rgb_cfg.sv
// Coefficient register file of the converter.
// Depends on yc2rgb_pkg.
`default_nettype none

module yc2rgb_cfg import yc2rgb_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  // Standard matrix at the coefficient scale
  localparam logic [COEF_W-1:0] LUMA_GAIN_RESET   =
    coef_fixed(LUMA_GAIN_MILLI, COEF_FRAC_BITS);
  localparam logic [COEF_W-1:0] CR_TO_RED_RESET   =
    coef_fixed(CR_TO_RED_MILLI, COEF_FRAC_BITS);
  localparam logic [COEF_W-1:0] CR_TO_GREEN_RESET =
    coef_fixed(CR_TO_GREEN_MILLI, COEF_FRAC_BITS);
  localparam logic [COEF_W-1:0] CB_TO_GREEN_RESET =
    coef_fixed(CB_TO_GREEN_MILLI, COEF_FRAC_BITS);
  localparam logic [COEF_W-1:0] CB_TO_BLUE_RESET  =
    coef_fixed(CB_TO_BLUE_MILLI, COEF_FRAC_BITS);

  cfg_t cfg_q;

  // Write one register per enabled cycle; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.luma_gain     <= LUMA_GAIN_RESET;
      cfg_q.luma_offset   <= LUMA_OFFSET_RESET;
      cfg_q.chroma_center <= CHROMA_CENTER_RESET;
      cfg_q.cr_to_red     <= CR_TO_RED_RESET;
      cfg_q.cr_to_green   <= CR_TO_GREEN_RESET;
      cfg_q.cb_to_green   <= CB_TO_GREEN_RESET;
      cfg_q.cb_to_blue    <= CB_TO_BLUE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LUMA_GAIN:     cfg_q.luma_gain     <= cfg_data_i[COEF_W-1:0];
        REG_LUMA_OFFSET:   cfg_q.luma_offset   <= cfg_data_i[PIX_W-1:0];
        REG_CHROMA_CENTER: cfg_q.chroma_center <= cfg_data_i[PIX_W-1:0];
        REG_CR_TO_RED:     cfg_q.cr_to_red     <= cfg_data_i[COEF_W-1:0];
        REG_CR_TO_GREEN:   cfg_q.cr_to_green   <= cfg_data_i[COEF_W-1:0];
        REG_CB_TO_GREEN:   cfg_q.cb_to_green   <= cfg_data_i[COEF_W-1:0];
        REG_CB_TO_BLUE:    cfg_q.cb_to_blue    <= cfg_data_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> hdl/yc2rgb_prod.sv
// Multiply logic: luma and chroma products for one pixel pair.
// Depends on yc2rgb_pkg.
`default_nettype none

module yc2rgb_prod import yc2rgb_pkg::*; (
  input  wire pix_in_t pix_i,
  input  wire cfg_t    cfg_i,
  output prod_t        prod_o
);

  logic signed [PIX_W:0]  dy_left;
  logic signed [PIX_W:0]  dy_right;
  logic signed [PIX_W:0]  dcr;
  logic signed [PIX_W:0]  dcb;

  // Remove black level and chroma center as 9-bit signed differences
  assign dy_left  = signed'({1'b0, pix_i.luma_left})   - signed'({1'b0, cfg_i.luma_offset});
  assign dy_right = signed'({1'b0, pix_i.luma_right})  - signed'({1'b0, cfg_i.luma_offset});
  assign dcr      = signed'({1'b0, pix_i.chroma_red})  - signed'({1'b0, cfg_i.chroma_center});
  assign dcb      = signed'({1'b0, pix_i.chroma_blue}) - signed'({1'b0, cfg_i.chroma_center});

  // Unsigned coefficient times signed difference; chroma terms are shared
  assign prod_o.yterm_left  = PROD_W'(signed'({1'b0, cfg_i.luma_gain}))   * PROD_W'(dy_left);
  assign prod_o.yterm_right = PROD_W'(signed'({1'b0, cfg_i.luma_gain}))   * PROD_W'(dy_right);
  assign prod_o.cr_red      = PROD_W'(signed'({1'b0, cfg_i.cr_to_red}))   * PROD_W'(dcr);
  assign prod_o.cr_green    = PROD_W'(signed'({1'b0, cfg_i.cr_to_green})) * PROD_W'(dcr);
  assign prod_o.cb_green    = PROD_W'(signed'({1'b0, cfg_i.cb_to_green})) * PROD_W'(dcb);
  assign prod_o.cb_blue     = PROD_W'(signed'({1'b0, cfg_i.cb_to_blue}))  * PROD_W'(dcb);

endmodule

`default_nettype wire

>>> hdl/yc2rgb_pixel.sv
// Sum, round and saturate logic for one pixel's three color channels.
// Depends on yc2rgb_pkg.
`default_nettype none

module yc2rgb_pixel import yc2rgb_pkg::*; (
  input  wire logic signed [PROD_W-1:0] yterm_i,
  input  wire logic signed [PROD_W-1:0] cr_red_i,
  input  wire logic signed [PROD_W-1:0] cr_green_i,
  input  wire logic signed [PROD_W-1:0] cb_green_i,
  input  wire logic signed [PROD_W-1:0] cb_blue_i,
  output logic [PIX_W-1:0]              blue_o,
  output logic [PIX_W-1:0]              green_o,
  output logic [PIX_W-1:0]              red_o
);

  localparam logic [ACC_W-1:0] HALF    = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [ACC_W-1:0] PIX_MAX = ACC_W'((1 << PIX_W) - 1);

  logic signed [ACC_W-1:0] acc_red;
  logic signed [ACC_W-1:0] acc_green;
  logic signed [ACC_W-1:0] acc_blue;

  // Negative clamps to zero, otherwise round half up and clamp to full scale
  function automatic logic [PIX_W-1:0] round_sat(logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0] rounded;
    rounded = (ACC_W'(unsigned'(acc)) + HALF) >> COEF_FRAC_BITS;
    if (acc[ACC_W-1]) begin
      return '0;
    end else if (rounded > PIX_MAX) begin
      return PIX_MAX[PIX_W-1:0];
    end else begin
      return rounded[PIX_W-1:0];
    end
  endfunction

  // Combine luma term with chroma terms
  assign acc_red   = ACC_W'(yterm_i) + ACC_W'(cr_red_i);
  assign acc_green = ACC_W'(yterm_i) - ACC_W'(cr_green_i) - ACC_W'(cb_green_i);
  assign acc_blue  = ACC_W'(yterm_i) + ACC_W'(cb_blue_i);

  assign red_o   = round_sat(acc_red);
  assign green_o = round_sat(acc_green);
  assign blue_o  = round_sat(acc_blue);

endmodule

`default_nettype wire

>>> hdl/ycbcr_to_rgb_pixel_pair.sv
// Top level of the pixel-pair YCbCr (limited range) to BGR converter.
// Depends on yc2rgb_pkg, yc2rgb_cfg, yc2rgb_prod and yc2rgb_pixel.
//
// Usage:
//   Input channel carries one pixel pair per transfer: two luma samples and
//   the shared Cr/Cb pair. Output channel returns the six saturated 8-bit
//   B, G, R values of the even and odd pixel, one result per input transfer,
//   in order. Both channels use valid/stall; a transfer happens on a clock
//   edge with valid high and stall low.
//   Path: an accepted pair loads the input register, then multiply, sum and
//   saturate results load the result register, which drives out_valid_o.
//   Throughput: one pair per clock while the output is not stalled; each
//   register loads whenever the one after it is empty or moving, so the
//   block accepts one more pair while a finished result waits.
//   Output stall: the input register fills behind the held result; input
//   stall rises only when both registers hold data and the output is stalled.
//   Reset: both registers empty, coefficients load the BT.601 defaults in
//   Q2.10, black level 16 and chroma center 128.
//   Configuration: write registers 0..6 through cfg_we_i/cfg_idx_i/cfg_data_i
//   only while the block is empty; other indexes are ignored.
`default_nettype none

module ycbcr_to_rgb_pixel_pair import yc2rgb_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire pix_in_t               in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output pix_out_t                   out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t     cfg;
  pix_in_t  in_q;
  logic     in_valid_q;
  prod_t    prod_d;
  pix_out_t res_d;
  pix_out_t res_q;
  logic     res_valid_q;
  logic     in_ready;
  logic     res_ready;

  yc2rgb_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cfg_o     (cfg)
  );

  // Stage handshake: a register loads when it is empty or its content moves on
  assign res_ready  = !res_valid_q || !out_stall_i;
  assign in_ready   = !in_valid_q || res_ready;
  assign in_stall_o = !in_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  yc2rgb_prod u_prod (
    .pix_i (in_q),
    .cfg_i (cfg),
    .prod_o(prod_d)
  );

  yc2rgb_pixel u_pixel_left (
    .yterm_i   (prod_d.yterm_left),
    .cr_red_i  (prod_d.cr_red),
    .cr_green_i(prod_d.cr_green),
    .cb_green_i(prod_d.cb_green),
    .cb_blue_i (prod_d.cb_blue),
    .blue_o    (res_d.blue_left),
    .green_o   (res_d.green_left),
    .red_o     (res_d.red_left)
  );

  yc2rgb_pixel u_pixel_right (
    .yterm_i   (prod_d.yterm_right),
    .cr_red_i  (prod_d.cr_red),
    .cr_green_i(prod_d.cr_green),
    .cb_green_i(prod_d.cb_green),
    .cb_blue_i (prod_d.cb_blue),
    .blue_o    (res_d.blue_right),
    .green_o   (res_d.green_right),
    .red_o     (res_d.red_right)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_ready) begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  // An accepted transfer always lands in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_valid_q)
    else $error("accepted input not captured");

  // Input stalls only when both registers are full and the output is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && res_valid_q && out_stall_i))
    else $error("input stalled with room in the block");

  // Inputs move into the result register whenever it can take them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && res_ready) |=> res_valid_q)
    else $error("input register lost an item");

  // A delivered result with nothing behind it leaves the output empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !out_stall_i && !in_valid_q) |=> !res_valid_q)
    else $error("result repeated after transfer");

endmodule

`default_nettype wire

>>> tb/tb_ycbcr_to_rgb_pixel_pair.sv
// Self-checking testbench for the pixel-pair YCbCr to BGR converter.
// Depends on yc2rgb_pkg and ycbcr_to_rgb_pixel_pair; drives random and directed
// pixel pairs under several coefficient sets and flow-control patterns.
module tb_ycbcr_to_rgb_pixel_pair;
  import yc2rgb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COEF_FRAC = COEF_FRAC_BITS;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
  // Index just past the register file, must be dropped by the block
  localparam logic [CFG_IDX_W-1:0] REG_PAST_END = 3'd7;

  // Coefficients the block holds after reset
  localparam cfg_t BT601_COEFS = '{
    luma_gain:     12'd1192,
    luma_offset:   8'd16,
    chroma_center: 8'd128,
    cr_to_red:     12'd1634,
    cr_to_green:   12'd833,
    cb_to_green:   12'd400,
    cb_to_blue:    12'd2066
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  pix_in_t               in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  pix_out_t              out_data_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  pix_in_t  pending_pix_q[$];
  pix_out_t expected_bgr_q[$];
  cfg_t     coef_now = BT601_COEFS;

  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_send = 1'b0;
  int  error_count = 0;
  int  result_count = 0;
  int  setting_count = 1;
  int  cycle_count = 0;

  string field_names[6] = '{"blue_left", "green_left", "red_left",
                            "blue_right", "green_right", "red_right"};

  ycbcr_to_rgb_pixel_pair dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Round half up, then clamp to the 8-bit pixel range
  function automatic logic [PIX_W-1:0] round_clip(longint acc);
    longint r;
    if (acc < 0) return '0;
    r = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    if (r > longint'(PIX_MAX)) return PIX_MAX;
    return r[PIX_W-1:0];
  endfunction

  // B, G, R of one pixel from its luma and the shared chroma offsets
  function automatic logic [3*PIX_W-1:0] pixel_bgr(logic [PIX_W-1:0] y, longint dcr,
                                                   longint dcb);
    longint yterm;
    yterm = longint'(coef_now.luma_gain) * (longint'(y) - longint'(coef_now.luma_offset));
    return {round_clip(yterm + longint'(coef_now.cb_to_blue) * dcb),
            round_clip(yterm - longint'(coef_now.cr_to_green) * dcr
                             - longint'(coef_now.cb_to_green) * dcb),
            round_clip(yterm + longint'(coef_now.cr_to_red) * dcr)};
  endfunction

  function automatic pix_out_t predict_bgr(pix_in_t px);
    longint dcr;
    longint dcb;
    dcr = longint'(px.chroma_red) - longint'(coef_now.chroma_center);
    dcb = longint'(px.chroma_blue) - longint'(coef_now.chroma_center);
    return {pixel_bgr(px.luma_left, dcr, dcb), pixel_bgr(px.luma_right, dcr, dcb)};
  endfunction

  // Lean toward the range ends now and then
  function automatic logic [PIX_W-1:0] random_sample();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return PIX_MAX;
    return PIX_W'($urandom_range(255));
  endfunction

  function automatic pix_in_t random_pair();
    pix_in_t px;
    px.luma_left   = random_sample();
    px.luma_right  = random_sample();
    px.chroma_red  = random_sample();
    px.chroma_blue = random_sample();
    return px;
  endfunction

  // Small spread around the standard matrix, or anything at all
  function automatic cfg_t random_setting(bit near_std);
    cfg_t s;
    if (near_std) begin
      s.luma_gain     = BT601_COEFS.luma_gain + COEF_W'($urandom_range(160)) - 12'd80;
      s.luma_offset   = PIX_W'($urandom_range(32));
      s.chroma_center = BT601_COEFS.chroma_center + PIX_W'($urandom_range(16)) - 8'd8;
      s.cr_to_red     = BT601_COEFS.cr_to_red + COEF_W'($urandom_range(200)) - 12'd100;
      s.cr_to_green   = BT601_COEFS.cr_to_green + COEF_W'($urandom_range(200)) - 12'd100;
      s.cb_to_green   = BT601_COEFS.cb_to_green + COEF_W'($urandom_range(200)) - 12'd100;
      s.cb_to_blue    = BT601_COEFS.cb_to_blue + COEF_W'($urandom_range(200)) - 12'd100;
    end else begin
      s.luma_gain     = COEF_W'($urandom);
      s.luma_offset   = PIX_W'($urandom);
      s.chroma_center = PIX_W'($urandom);
      s.cr_to_red     = COEF_W'($urandom);
      s.cr_to_green   = COEF_W'($urandom);
      s.cb_to_green   = COEF_W'($urandom);
      s.cb_to_blue    = COEF_W'($urandom);
    end
    return s;
  endfunction

  // Write one register and track it; the 8-bit registers keep their low bits
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_LUMA_GAIN:     coef_now.luma_gain = data;
      REG_LUMA_OFFSET:   coef_now.luma_offset = data[PIX_W-1:0];
      REG_CHROMA_CENTER: coef_now.chroma_center = data[PIX_W-1:0];
      REG_CR_TO_RED:     coef_now.cr_to_red = data;
      REG_CR_TO_GREEN:   coef_now.cr_to_green = data;
      REG_CB_TO_GREEN:   coef_now.cb_to_green = data;
      REG_CB_TO_BLUE:    coef_now.cb_to_blue = data;
      default: ;
    endcase
  endtask

  // Load a full coefficient set, junk in the unused upper bits of 8-bit registers
  task automatic load_setting(input cfg_t s);
    write_reg(REG_LUMA_GAIN, s.luma_gain);
    write_reg(REG_LUMA_OFFSET, {4'($urandom_range(15)), s.luma_offset});
    write_reg(REG_CHROMA_CENTER, {4'($urandom_range(15)), s.chroma_center});
    write_reg(REG_CR_TO_RED, s.cr_to_red);
    write_reg(REG_CR_TO_GREEN, s.cr_to_green);
    write_reg(REG_CB_TO_GREEN, s.cb_to_green);
    write_reg(REG_CB_TO_BLUE, s.cb_to_blue);
    setting_count++;
  endtask

  // Queue random pairs and wait until every result is back
  task automatic run_phase(input int count, input int idle, input int stall,
                           input bit pause);
    int i;
    idle_pct  = idle;
    stall_pct = stall;
    for (i = 0; i < count; i++) pending_pix_q.push_back(random_pair());
    if (pause) begin
      do @(posedge clk_i); while (pending_pix_q.size() > count / 2);
      // Hold the sender until the pipeline has fully drained
      hold_send = 1'b1;
      do @(posedge clk_i); while (in_valid_i || expected_bgr_q.size() != 0);
      hold_send = 1'b0;
    end
    do @(posedge clk_i);
    while (pending_pix_q.size() != 0 || in_valid_i || expected_bgr_q.size() != 0);
  endtask

  // Driver: record each input transfer, then present the next pair or idle
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) expected_bgr_q.push_back(predict_bgr(in_data_i));
    if (!in_valid_i || !in_stall_o) begin
      if (rst_ni && !hold_send && pending_pix_q.size() != 0 &&
          $urandom_range(99) >= idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_pix_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: check each output transfer against the oldest prediction
  always @(posedge clk_i) begin
    pix_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_count++;
      if (expected_bgr_q.size() == 0) begin
        $error("unexpected result %h with nothing pending", out_data_o);
        error_count++;
      end else begin
        want = expected_bgr_q.pop_front();
        for (int f = 0; f < 6; f++) begin
          if (out_data_o[47-8*f -: 8] !== want[47-8*f -: 8]) begin
            $error("%s: expected %0d, got %0d", field_names[f],
                   want[47-8*f -: 8], out_data_o[47-8*f -: 8]);
            error_count++;
          end
        end
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed pairs on the reset matrix: range ends, luma under black level,
    // sums that go negative and sums that overflow
    pending_pix_q.push_back('{8'd0, 8'd0, 8'd0, 8'd0});
    pending_pix_q.push_back('{8'd255, 8'd255, 8'd255, 8'd255});
    pending_pix_q.push_back('{8'd16, 8'd235, 8'd128, 8'd128});
    pending_pix_q.push_back('{8'd0, 8'd15, 8'd128, 8'd128});
    pending_pix_q.push_back('{8'd255, 8'd255, 8'd255, 8'd0});
    pending_pix_q.push_back('{8'd255, 8'd255, 8'd0, 8'd255});
    pending_pix_q.push_back('{8'd0, 8'd0, 8'd255, 8'd0});
    pending_pix_q.push_back('{8'd0, 8'd0, 8'd0, 8'd255});
    pending_pix_q.push_back('{8'd235, 8'd16, 8'd240, 8'd16});
    pending_pix_q.push_back('{8'd16, 8'd235, 8'd16, 8'd240});
    pending_pix_q.push_back('{8'd128, 8'd128, 8'd128, 8'd128});
    pending_pix_q.push_back('{8'd255, 8'd0, 8'd128, 8'd128});
    pending_pix_q.push_back('{8'd81, 8'd145, 8'd90, 8'd54});
    pending_pix_q.push_back('{8'd170, 8'd41, 8'd16, 8'd166});
    pending_pix_q.push_back('{8'd1, 8'd254, 8'd127, 8'd129});
    pending_pix_q.push_back('{8'd17, 8'd15, 8'd129, 8'd127});
    pending_pix_q.push_back('{8'd126, 8'd130, 8'd200, 8'd60});
    pending_pix_q.push_back('{8'd200, 8'd100, 8'd60, 8'd200});
    pending_pix_q.push_back('{8'd255, 8'd255, 8'd128, 8'd0});
    run_phase(250, 0, 0, 1'b0);

    // All coefficients at their maximum
    load_setting('{12'hFFF, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});
    run_phase(150, 77, 0, 1'b0);

    // All zero, then a dropped write past the end, wide 8-bit values and unity luma gain
    load_setting('0);
    write_reg(REG_PAST_END, COEF_W'($urandom));
    write_reg(REG_LUMA_OFFSET, 12'hA05);
    write_reg(REG_CHROMA_CENTER, 12'h37C);
    write_reg(REG_LUMA_GAIN, 12'd1024);
    run_phase(150, 0, 77, 1'b0);

    load_setting(random_setting(1'b0));
    run_phase(150, 20, 20, 1'b1);

    load_setting(random_setting(1'b1));
    run_phase(200, 77, 0, 1'b0);

    load_setting(random_setting(1'b1));
    run_phase(200, 0, 77, 1'b0);

    load_setting(random_setting(1'b0));
    run_phase(175, 20, 20, 1'b0);

    // Back to the standard matrix, with a stray write in between
    write_reg(REG_PAST_END, 12'hFFF);
    load_setting(BT601_COEFS);
    run_phase(175, 20, 20, 1'b0);

    // Let the pipeline settle and catch any stray output
    idle_pct  = 0;
    stall_pct = 0;
    repeat (10) @(posedge clk_i);
    if (expected_bgr_q.size() != 0) begin
      $error("%0d results never arrived", expected_bgr_q.size());
      error_count++;
    end

    $display("Converted %0d pixel pairs across %0d coefficient sets, idle and stall mixes",
             result_count, setting_count);
    $display("Mismatches and protocol errors: %0d", error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/yc2rgb_pkg.sv
hdl/yc2rgb_cfg.sv
hdl/yc2rgb_prod.sv
hdl/yc2rgb_pixel.sv
hdl/ycbcr_to_rgb_pixel_pair.sv
tb/tb_ycbcr_to_rgb_pixel_pair.sv
